// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros for checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define GRT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define GRT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: design/grt_pkg.sv
// ----------------------------------------------------------------------------
// grt_pkg
// Shared types and constants for the grid ray trace engine.
// ----------------------------------------------------------------------------
package grt_pkg;
  localparam int unsigned GridSizeDef = 256;
  localparam int unsigned CoordW = 12;
  localparam int unsigned CellW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 12;
  localparam logic signed [CellW-1:0] MarkHalfUnits = 8'sd7;

  typedef enum logic [1:0] {
    OP_SCAN = 2'd0,
    OP_PROBE = 2'd1,
    OP_PAINT_FREE = 2'd2,
    OP_PAINT_OCC = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_THRESH = 3'd0,
    REG_DEC = 3'd1,
    REG_FLOOR = 3'd2,
    REG_CEIL = 3'd3,
    REG_SCROLL_X = 3'd4,
    REG_SCROLL_Y = 3'd5,
    REG_RANGE = 3'd6
  } reg_e;

  // Classified line job passed from front to back.
  typedef struct packed {
    op_e op;
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic [CoordW:0] dx2;          // 2*|dx|, up to 8190
    logic [CoordW:0] dy2;          // 2*|dy|
    logic sx_neg;
    logic sy_neg;
    logic x_major;
    logic mark_ok;                 // scan end in range and nonzero length
  } job_t;

  typedef enum logic [3:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RD,
    BK_WAIT,
    BK_WR,
    BK_MRD,
    BK_MWAIT,
    BK_MWR,
    BK_DONE
  } bk_state_e;
endpackage

// File: design/grt_ram.sv
// ----------------------------------------------------------------------------
// grt_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module grt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: design/grt_front.sv
// ----------------------------------------------------------------------------
// grt_front
// Accepts requests, computes line deltas and scan range check.
// ----------------------------------------------------------------------------
module grt_front import grt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [1:0]               opcode_i,
  input  logic signed [CoordW-1:0] start_x_i,
  input  logic signed [CoordW-1:0] start_y_i,
  input  logic signed [CoordW-1:0] end_x_i,
  input  logic signed [CoordW-1:0] end_y_i,
  input  logic [11:0]              range_i,
  output logic                     job_valid_o,
  input  logic                     job_ready_i,
  output job_t                     job_o
);
  // stage 0: deltas; stage 1: squares; stage 2: sum and compare
  logic [1:0] phase_q, phase_d;
  job_t job_q, job_d;
  logic [CoordW:0] adx_q, ady_q, adx_d, ady_d;
  logic [2*CoordW+1:0] sqx_q, sqy_q, sqx_d, sqy_d;
  logic signed [CoordW:0] ddx, ddy;

  assign stall_o = (phase_q != 2'd0);
  assign job_valid_o = (phase_q == 2'd3);
  assign job_o = job_q;

  always_comb begin
    phase_d = phase_q;
    job_d = job_q;
    adx_d = adx_q;
    ady_d = ady_q;
    sqx_d = sqx_q;
    sqy_d = sqy_q;
    ddx = {end_x_i[CoordW-1], end_x_i} - {start_x_i[CoordW-1], start_x_i};
    ddy = {end_y_i[CoordW-1], end_y_i} - {start_y_i[CoordW-1], start_y_i};
    unique case (phase_q)
      2'd0: if (valid_i) begin
        job_d.op = op_e'(opcode_i);
        job_d.x0 = start_x_i;
        job_d.y0 = start_y_i;
        job_d.x1 = end_x_i;
        job_d.y1 = end_y_i;
        job_d.sx_neg = ddx[CoordW];
        job_d.sy_neg = ddy[CoordW];
        adx_d = ddx[CoordW] ? -ddx : ddx;
        ady_d = ddy[CoordW] ? -ddy : ddy;
        phase_d = 2'd1;
      end
      2'd1: begin
        job_d.dx2 = {adx_q[CoordW-1:0], 1'b0};
        job_d.dy2 = {ady_q[CoordW-1:0], 1'b0};
        job_d.x_major = (adx_q > ady_q);
        sqx_d = (2*CoordW+2)'(adx_q * adx_q);
        sqy_d = (2*CoordW+2)'(ady_q * ady_q);
        phase_d = 2'd2;
      end
      2'd2: begin
        job_d.mark_ok = ((sqx_q + sqy_q) != '0) &&
                        ({1'b0, sqx_q + sqy_q} < (2*CoordW+3)'(range_i * range_i));
        phase_d = 2'd3;
      end
      default: if (job_ready_i) begin
        phase_d = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    adx_q <= adx_d;
    ady_q <= ady_d;
    sqx_q <= sqx_d;
    sqy_q <= sqy_d;
  end
endmodule

// File: design/grt_back.sv
// ----------------------------------------------------------------------------
// grt_back
// Walks one Bresenham line over the grid RAM, read-modify-write per cell.
// ----------------------------------------------------------------------------
module grt_back import grt_pkg::*; #(
  parameter int unsigned GridSize = GridSizeDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     job_valid_i,
  output logic                     job_ready_o,
  input  job_t                     job_i,
  input  logic signed [6:0]        thresh_i,
  input  logic [5:0]               dec_i,
  input  logic signed [6:0]        floor_i,
  input  logic signed [6:0]        ceil_i,
  input  logic signed [7:0]        scroll_x_i,
  input  logic signed [7:0]        scroll_y_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic                     hit_o,
  output logic signed [CoordW-1:0] hit_x_o,
  output logic signed [CoordW-1:0] hit_y_o
);
  localparam int unsigned IdxW = $clog2(GridSize);
  localparam int unsigned AddrW = $clog2(GridSize * GridSize);
  localparam int unsigned Half = GridSize / 2;
  localparam int unsigned FracW = CoordW + 3;

  bk_state_e state_q, state_d;
  job_t job_q, job_d;
  logic signed [CoordW-1:0] x_q, y_q, x_d, y_d;
  logic signed [FracW-1:0] frac_q, frac_d;
  logic first_q, first_d;
  logic valid_q, valid_d, hit_q, hit_d;
  logic signed [CoordW-1:0] hx_q, hy_q, hx_d, hy_d;
  // result held for the output channel while the next line is walked
  logic res_hit_q, res_hit_d;
  logic signed [CoordW-1:0] res_x_q, res_y_q, res_x_d, res_y_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;

  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [CellW-1:0] ram_wdata, ram_rdata;

  // cell address for the current (or end) position
  logic signed [CoordW-1:0] px, py;
  logic pos_ok;
  logic signed [CoordW+1:0] cx_raw, cy_raw;
  logic [IdxW-1:0] cx, cy;
  logic signed [CellW+1:0] dec_v, fl_v;
  logic signed [CellW-1:0] rd_cell, fl8, ce8, th8;
  logic at_end;

  // GridSize is a power of two: the low index bits are the true modulo
  function automatic logic [IdxW-1:0] wrap(input logic signed [CoordW+1:0] v);
    return v[IdxW-1:0];
  endfunction

  always_comb begin
    px = (state_q == BK_MRD) ? job_q.x1 : x_q;
    py = (state_q == BK_MRD) ? job_q.y1 : y_q;
    pos_ok = (px < $signed(CoordW'(Half))) && (py < $signed(CoordW'(Half))) &&
             (px > -$signed(CoordW'(Half))) && (py > -$signed(CoordW'(Half)));
    cx_raw = (CoordW+2)'(px) + $signed((CoordW+2)'(Half)) + (CoordW+2)'(scroll_x_i);
    cy_raw = (CoordW+2)'(py) + $signed((CoordW+2)'(Half)) + (CoordW+2)'(scroll_y_i);
    cx = wrap(cx_raw);
    cy = wrap(cy_raw);
  end

  assign ram_addr = (state_q == BK_CLEAR) ? clr_addr_q : AddrW'({cx, cy});
  assign rd_cell = $signed(ram_rdata);
  assign fl8 = {floor_i, 1'b0};
  assign ce8 = {ceil_i, 1'b0};
  assign th8 = {thresh_i, 1'b0};
  assign at_end = job_q.x_major ? (x_q == job_q.x1) : (y_q == job_q.y1);

  grt_ram #(.Width(CellW), .Depth(GridSize * GridSize)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign job_ready_o = (state_q == BK_IDLE);
  assign valid_o = valid_q;
  assign hit_o = res_hit_q;
  assign hit_x_o = res_x_q;
  assign hit_y_o = res_y_q;

  always_comb begin
    state_d = state_q;
    job_d = job_q;
    x_d = x_q;
    y_d = y_q;
    frac_d = frac_q;
    first_d = first_q;
    valid_d = valid_q && stall_i;
    hit_d = hit_q;
    hx_d = hx_q;
    hy_d = hy_q;
    res_hit_d = res_hit_q;
    res_x_d = res_x_q;
    res_y_d = res_y_q;
    clr_addr_d = clr_addr_q;
    ram_we = 1'b0;
    ram_wdata = '0;
    dec_v = $signed({3'b0, dec_i, 1'b0});
    fl_v = (CellW+2)'(fl8);
    unique case (state_q)
      BK_CLEAR: begin
        // zero one cell per cycle after reset
        ram_we = 1'b1;
        clr_addr_d = clr_addr_q + AddrW'(1);
        if (clr_addr_q == '1) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: if (job_valid_i) begin
        job_d = job_i;
        x_d = job_i.x0;
        y_d = job_i.y0;
        first_d = 1'b1;
        hit_d = 1'b0;
        hx_d = '0;
        hy_d = '0;
        frac_d = job_i.x_major ?
          FracW'(job_i.dy2) - FracW'(job_i.dx2 >>> 1) :
          FracW'(job_i.dx2) - FracW'(job_i.dy2 >>> 1);
        state_d = BK_RD;
      end
      BK_RD: begin
        state_d = pos_ok ? BK_WAIT : BK_WR;
      end
      BK_WAIT: state_d = BK_WR;
      BK_WR: begin
        // apply op when the position was in window
        if (pos_ok) begin
          unique case (job_q.op)
            OP_SCAN: begin
              ram_we = 1'b1;
              ram_wdata = ((CellW+2)'(rd_cell) - dec_v < fl_v) ? fl8 :
                          CellW'((CellW+2)'(rd_cell) - dec_v);
            end
            OP_PROBE: ;
            OP_PAINT_FREE: begin
              ram_we = 1'b1;
              ram_wdata = fl8;
            end
            default: begin
              ram_we = 1'b1;
              ram_wdata = ce8;
            end
          endcase
        end
        if (job_q.op == OP_PROBE && pos_ok && !first_q && rd_cell >= th8) begin
          hit_d = 1'b1;
          hx_d = x_q;
          hy_d = y_q;
          state_d = BK_DONE;
        end else if (at_end) begin
          state_d = (job_q.op == OP_SCAN && job_q.mark_ok) ? BK_MRD : BK_DONE;
        end else begin
          // Bresenham step
          first_d = 1'b0;
          if (job_q.x_major) begin
            if (!frac_q[FracW-1]) begin
              y_d = job_q.sy_neg ? y_q - 1'b1 : y_q + 1'b1;
              frac_d = frac_q - FracW'(job_q.dx2) + FracW'(job_q.dy2);
            end else begin
              frac_d = frac_q + FracW'(job_q.dy2);
            end
            x_d = job_q.sx_neg ? x_q - 1'b1 : x_q + 1'b1;
          end else begin
            if (!frac_q[FracW-1]) begin
              x_d = job_q.sx_neg ? x_q - 1'b1 : x_q + 1'b1;
              frac_d = frac_q - FracW'(job_q.dy2) + FracW'(job_q.dx2);
            end else begin
              frac_d = frac_q + FracW'(job_q.dx2);
            end
            y_d = job_q.sy_neg ? y_q - 1'b1 : y_q + 1'b1;
          end
          state_d = BK_RD;
        end
      end
      BK_MRD: begin
        state_d = pos_ok ? BK_MWAIT : BK_DONE;
        x_d = job_q.x1;
        y_d = job_q.y1;
      end
      BK_MWAIT: state_d = BK_MWR;
      BK_MWR: begin
        ram_we = 1'b1;
        ram_wdata = rd_cell[CellW-1] ? MarkHalfUnits : ce8;
        state_d = BK_DONE;
      end
      default: if (!valid_q || !stall_i) begin
        valid_d = 1'b1;
        res_hit_d = hit_q;
        res_x_d = hx_q;
        res_y_d = hy_q;
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR;
      valid_q <= 1'b0;
      clr_addr_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    x_q <= x_d;
    y_q <= y_d;
    frac_q <= frac_d;
    first_q <= first_d;
    hit_q <= hit_d;
    hx_q <= hx_d;
    hy_q <= hy_d;
    res_hit_q <= res_hit_d;
    res_x_q <= res_x_d;
    res_y_q <= res_y_d;
  end
endmodule

// File: design/grid_ray_trace_engine.sv
// ----------------------------------------------------------------------------
// grid_ray_trace_engine
// Scrolling occupancy grid with Bresenham line walks.
// ----------------------------------------------------------------------------
// One request walks a line from start to end cell in the grid RAM; a probe
// stops at its first hit. After reset the back zeroes all GridSize*GridSize
// cells (65536 at the default size), one cell per cycle, before it takes the
// first line; a request accepted meanwhile waits in the front. A visited cell
// inside the window passes the states address, registered read and write, one
// outside it only address and a skipped write, and marking a scan end in the
// window takes its own address, read and write states. The single grid RAM
// port sets the pace of the walk. The front computes deltas and the squared
// range check while the back walks the previous line, and a finished result
// waits in its own output register. GridSize must be a power of two.
module grid_ray_trace_engine import grt_pkg::*; #(
  parameter int unsigned GridSize = GridSizeDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [1:0]               opcode_i,
  input  logic signed [CoordW-1:0] start_x_i,
  input  logic signed [CoordW-1:0] start_y_i,
  input  logic signed [CoordW-1:0] end_x_i,
  input  logic signed [CoordW-1:0] end_y_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic                     hit_o,
  output logic signed [CoordW-1:0] hit_x_o,
  output logic signed [CoordW-1:0] hit_y_o
);
  logic signed [6:0] thresh_q, floor_q, ceil_q;
  logic [5:0] dec_q;
  logic signed [7:0] sx_q, sy_q;
  logic [11:0] range_q;
  logic job_valid, job_ready;
  job_t job;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= 7'sd20;
      dec_q <= 6'd2;
      floor_q <= -7'sd40;
      ceil_q <= 7'sd40;
      sx_q <= '0;
      sy_q <= '0;
      range_q <= 12'd100;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_THRESH: thresh_q <= cfg_data_i[6:0];
        REG_DEC: dec_q <= cfg_data_i[5:0];
        REG_FLOOR: floor_q <= cfg_data_i[6:0];
        REG_CEIL: ceil_q <= cfg_data_i[6:0];
        REG_SCROLL_X: sx_q <= cfg_data_i[7:0];
        REG_SCROLL_Y: sy_q <= cfg_data_i[7:0];
        REG_RANGE: range_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  grt_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .opcode_i, .start_x_i, .start_y_i,
    .end_x_i, .end_y_i,
    .range_i    (range_q),
    .job_valid_o(job_valid),
    .job_ready_i(job_ready),
    .job_o      (job)
  );

  grt_back #(.GridSize(GridSize)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid),
    .job_ready_o(job_ready),
    .job_i      (job),
    .thresh_i   (thresh_q),
    .dec_i      (dec_q),
    .floor_i    (floor_q),
    .ceil_i     (ceil_q),
    .scroll_x_i (sx_q),
    .scroll_y_i (sy_q),
    .valid_o, .stall_i, .hit_o, .hit_x_o, .hit_y_o
  );
endmodule

// File: design/grt_checker.sv
// ----------------------------------------------------------------------------
// grt_checker
// Port-level checks for the grid ray trace engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module grt_checker import grt_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     valid_o,
  input logic                     stall_i,
  input logic                     hit_o,
  input logic signed [CoordW-1:0] hit_x_o,
  input logic signed [CoordW-1:0] hit_y_o
);
  `GRT_ASSERT_IMP(a_nohit_zero, clk_i, rst_ni, valid_o && !hit_o, hit_x_o == '0 && hit_y_o == '0)
  `GRT_ASSERT_NXT(a_hold, clk_i, rst_ni, valid_o && stall_i, valid_o && $stable(hit_x_o))
  `GRT_ASSERT_NXT(a_hold_hit, clk_i, rst_ni, valid_o && stall_i, $stable(hit_o))
endmodule

bind grid_ray_trace_engine grt_checker u_checker (.*);

// File: tb/grid_ray_trace_engine_tb.sv
// ----------------------------------------------------------------------------
// grid_ray_trace_engine_tb
// Self-checking bench for the grid ray trace engine. A behavioral model of
// the occupancy grid predicts every line request; results are checked field
// by field in order. The grid starts at zero after reset. Then come directed
// corner cases and random lines under several register settings, with random
// idling on both sides.
// ----------------------------------------------------------------------------
module grid_ray_trace_engine_tb;
  import grt_pkg::*;

  localparam int unsigned HalfGrid  = GridSizeDef / 2;
  localparam int unsigned CycleCap  = 6000000;
  localparam int unsigned DrainWait = 64;

  typedef struct packed {
    logic             hit;
    logic [CoordW-1:0] hx;
    logic [CoordW-1:0] hy;
  } line_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i = '0;
  logic [CfgDataW-1:0]      cfg_data_i = '0;
  logic                     valid_i = 1'b0;
  logic                     stall_o;
  logic [1:0]               opcode_i = '0;
  logic signed [CoordW-1:0] start_x_i = '0;
  logic signed [CoordW-1:0] start_y_i = '0;
  logic signed [CoordW-1:0] end_x_i = '0;
  logic signed [CoordW-1:0] end_y_i = '0;
  logic                     valid_o;
  logic                     stall_i = 1'b0;
  logic                     hit_o;
  logic signed [CoordW-1:0] hit_x_o;
  logic signed [CoordW-1:0] hit_y_o;

  grid_ray_trace_engine i_dut (.*);

  always #4 clk_i = ~clk_i;

  // Model state: grid in half units, signed registers sign-extended.
  logic signed [CellW-1:0] occ_grid [GridSizeDef*GridSizeDef];
  int thresh_r, dec_r, floor_r, ceil_r, scroll_x_r, scroll_y_r, range_r;

  line_result_t pending_results[$];
  int  errors;
  int  req_count;
  int  hits_seen;
  int  results_seen;
  int unsigned cycles;
  bit  quiet;   // when set, neither side idles

  // ---------------------------------------------------------------------------
  // Grid model
  // ---------------------------------------------------------------------------
  function automatic int wrap_coord(int v);
    int r;
    r = v % int'(GridSizeDef);
    if (r < 0) r += GridSizeDef;
    return r;
  endfunction

  // Flat cell index, or -1 outside the open half-grid window.
  function automatic int grid_index(int x, int y);
    int h;
    h = HalfGrid;
    if (!(x < h && y < h && x > -h && y > -h)) return -1;
    return wrap_coord(x + h + scroll_x_r) * GridSizeDef + wrap_coord(y + h + scroll_y_r);
  endfunction

  // Applies one opcode to one position; returns a probe hit.
  function automatic bit visit_cell(op_e op, int x, int y);
    int i, c, f;
    i = grid_index(x, y);
    if (i < 0) return 1'b0;
    c = occ_grid[i];
    case (op)
      OP_SCAN: begin
        f = 2 * floor_r;
        c = c - 2 * dec_r;
        occ_grid[i] = CellW'((c < f) ? f : c);
      end
      OP_PROBE: return c >= 2 * thresh_r;
      OP_PAINT_FREE: occ_grid[i] = CellW'(2 * floor_r);
      default: occ_grid[i] = CellW'(2 * ceil_r);
    endcase
    return 1'b0;
  endfunction

  // Bresenham walk plus scan end marking; returns the expected result.
  function automatic line_result_t trace_line(op_e op, int x0, int y0, int x1, int y1);
    line_result_t res;
    int dx, dy, sx, sy, frac, hx, hy, i;
    bit hit;
    longint ex, ey, d2, rr;
    dx = x1 - x0; dy = y1 - y0; sx = 1; sy = 1;
    hit = 1'b0; hx = 0; hy = 0;
    if (dy < 0) begin dy = -dy; sy = -1; end
    if (dx < 0) begin dx = -dx; sx = -1; end
    dy *= 2; dx *= 2;
    void'(visit_cell(op, x0, y0));
    begin
      int cx, cy;
      cx = x0; cy = y0;
      if (dx > dy) begin
        frac = dy - dx / 2;
        while (cx != x1 && !hit) begin
          if (frac >= 0) begin cy += sy; frac -= dx; end
          cx += sx; frac += dy;
          if (visit_cell(op, cx, cy)) begin hit = 1'b1; hx = cx; hy = cy; end
        end
      end else begin
        frac = dx - dy / 2;
        while (cy != y1 && !hit) begin
          if (frac >= 0) begin cx += sx; frac -= dy; end
          cy += sy; frac += dx;
          if (visit_cell(op, cx, cy)) begin hit = 1'b1; hx = cx; hy = cy; end
        end
      end
    end
    if (op == OP_SCAN) begin
      ex = x1 - x0; ey = y1 - y0;
      d2 = ex * ex + ey * ey;
      rr = longint'(range_r) * range_r;
      i = grid_index(x1, y1);
      if (d2 != 0 && d2 < rr && i >= 0)
        occ_grid[i] = (occ_grid[i] < 0) ? MarkHalfUnits : CellW'(2 * ceil_r);
    end
    if (op != OP_PROBE || !hit) begin hit = 1'b0; hx = 0; hy = 0; end
    res.hit = hit;
    res.hx = hx[CoordW-1:0];
    res.hy = hy[CoordW-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 32);
  endfunction

  always @(posedge clk_i) stall_i <= idle_now();

  // Sends one request; the model runs at the accepting edge.
  task automatic send_line(op_e op, int x0, int y0, int x1, int y1);
    line_result_t line_exp;
    while (idle_now()) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i   <= 1'b1;
    opcode_i  <= op;
    start_x_i <= x0[CoordW-1:0];
    start_y_i <= y0[CoordW-1:0];
    end_x_i   <= x1[CoordW-1:0];
    end_y_i   <= y1[CoordW-1:0];
    forever begin
      @(negedge clk_i);
      if (!stall_o) break;
    end
    @(posedge clk_i);
    line_exp = trace_line(op, x0, y0, x1, y1);
    pending_results = {pending_results, line_exp};
    req_count++;
  endtask

  // Waits for every result, then a pause so the engine is surely idle.
  task automatic drain();
    if (valid_i) begin
      @(posedge clk_i);
      valid_i <= 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_THRESH:   thresh_r   = $signed(value[6:0]);
      REG_DEC:      dec_r      = value[5:0];
      REG_FLOOR:    floor_r    = $signed(value[6:0]);
      REG_CEIL:     ceil_r     = $signed(value[6:0]);
      REG_SCROLL_X: scroll_x_r = $signed(value[7:0]);
      REG_SCROLL_Y: scroll_y_r = $signed(value[7:0]);
      default:      range_r    = value[11:0];
    endcase
  endtask

  task automatic set_regs(int th, int dc, int fl, int ce, int scx, int scy, int rg);
    write_reg(REG_THRESH, th);
    write_reg(REG_DEC, dc);
    write_reg(REG_FLOOR, fl);
    write_reg(REG_CEIL, ce);
    write_reg(REG_SCROLL_X, scx);
    write_reg(REG_SCROLL_Y, scy);
    write_reg(REG_RANGE, rg);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: samples mid-cycle, so the coming edge accepts it
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    line_result_t exp_r;
    if (rst_ni && valid_o && !stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result hit=%0b x=%0d y=%0d", $time, hit_o,
                 hit_x_o, hit_y_o);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (hit_o) hits_seen++;
        if (hit_o !== exp_r.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, hit_o);
          errors++;
        end
        if (hit_x_o !== exp_r.hx) begin
          $display("%0t: hit_x expected %0d actual %0d", $time,
                   $signed(exp_r.hx), hit_x_o);
          errors++;
        end
        if (hit_y_o !== exp_r.hy) begin
          $display("%0t: hit_y expected %0d actual %0d", $time,
                   $signed(exp_r.hy), hit_y_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Cells read as zero after reset: with the threshold at zero the first
  // cell past the start is a hit.
  task automatic test_reset_state();
    write_reg(REG_THRESH, 0);
    send_line(OP_PROBE, -3, 2, 6, 2);
    drain();
    write_reg(REG_THRESH, 20);
  endtask

  task automatic test_probe();
    send_line(OP_PAINT_OCC, 5, 5, 5, 5);
    send_line(OP_PROBE, 5, 5, 15, 5);         // occupied start is not reported
    send_line(OP_PAINT_OCC, 9, 7, 9, 7);
    send_line(OP_PROBE, 0, 5, 20, 9);         // shallow line, hit on the way
    send_line(OP_PAINT_OCC, 3, -20, 3, -20);
    send_line(OP_PROBE, 0, 0, 6, -40);        // steep line
    send_line(OP_PROBE, -10, -10, -30, -30);  // nothing there
    send_line(OP_PROBE, 0, 0, 0, 0);
  endtask

  task automatic test_scan();
    send_line(OP_SCAN, 0, 0, 10, 3);          // end scanned below zero, marked 3.5
    send_line(OP_SCAN, 20, 20, 20, 20);       // zero length, no mark
    send_line(OP_PAINT_FREE, 30, 0, 30, 0);
    send_line(OP_SCAN, 25, 0, 30, 0);         // negative end becomes 3.5
    send_line(OP_PROBE, 24, 0, 35, 0);
    send_line(OP_SCAN, 0, 0, 120, 140);       // end outside window
    send_line(OP_SCAN, -126, 126, 127, -127); // diagonal across the window, ends near corners
    drain();
    write_reg(REG_RANGE, 0);                  // nothing in range
    send_line(OP_SCAN, 0, 0, 4, 4);
    drain();
    write_reg(REG_RANGE, 4095);
    write_reg(REG_FLOOR, 40);                 // cells below floor get lifted
    write_reg(REG_DEC, 0);
    send_line(OP_SCAN, -50, 10, -40, 12);
    send_line(OP_PROBE, -51, 10, -39, 12);
    drain();
    set_regs(20, 2, -40, 40, 0, 0, 100);
  endtask

  task automatic test_extremes();
    send_line(OP_PAINT_OCC, -2048, -2048, 2047, 2047);
    send_line(OP_PROBE, 2047, -2048, -2048, 2047);
    send_line(OP_PAINT_FREE, -2048, 0, 2047, 0);
    send_line(OP_SCAN, 0, 2047, 0, -2048);
    send_line(OP_PROBE, -128, -128, 128, 128);
  endtask

  task automatic randomize_regs(int phase);
    int th, dc, fl, ce, rg;
    th = $urandom_range(80) - 40;
    dc = $urandom_range(40);
    fl = $urandom_range(80) - 40;
    ce = $urandom_range(80) - 40;
    rg = $urandom_range(4095);
    case (phase % 4)
      0: begin th = -40; dc = 40; fl = -40; ce = 40; rg = 4095; end
      1: begin th = 40; dc = 0; fl = 40; ce = -40; rg = 0; end
      default: ;
    endcase
    if ($urandom_range(1)) rg = $urandom_range(60);
    set_regs(th, dc, fl, ce, $urandom_range(255), $urandom_range(255), rg);
  endtask

  task automatic test_random(int total);
    int x0, y0, x1, y1, pick, n;
    op_e op;
    for (n = 0; n < total; n++) begin
      if (n % 150 == 0) begin
        drain();
        randomize_regs(n / 150);
      end
      quiet = (n >= 450 && n < 560);
      pick = $urandom_range(99);
      op = (pick < 40) ? OP_SCAN : (pick < 70) ? OP_PROBE :
           (pick < 85) ? OP_PAINT_OCC : OP_PAINT_FREE;
      pick = $urandom_range(99);
      if (pick < 3) begin
        x0 = $signed(12'($urandom)); y0 = $signed(12'($urandom));
        x1 = $signed(12'($urandom)); y1 = $signed(12'($urandom));
      end else if (pick < 10) begin
        x0 = $urandom_range(270) - 135; y0 = $urandom_range(270) - 135;
        x1 = x0 + $urandom_range(16) - 8; y1 = y0 + $urandom_range(16) - 8;
      end else begin
        x0 = $urandom_range(254) - 127; y0 = $urandom_range(254) - 127;
        x1 = x0 + $urandom_range(48) - 24; y1 = y0 + $urandom_range(48) - 24;
      end
      send_line(op, x0, y0, x1, y1);
    end
    quiet = 1'b0;
  endtask

  initial begin
    errors = 0; req_count = 0; hits_seen = 0; results_seen = 0; cycles = 0;
    quiet = 1'b0;
    thresh_r = 20; dec_r = 2; floor_r = -40; ceil_r = 40;
    scroll_x_r = 0; scroll_y_r = 0; range_r = 100;
    foreach (occ_grid[i]) occ_grid[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_probe();
    test_scan();
    test_extremes();
    test_random(1026);
    drain();
    $display("covered %0d line requests, %0d results checked, %0d probe hits",
             req_count, results_seen, hits_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
